### hw/rtl/bftr_pkg.sv
`default_nettype none
package bftr_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_VIS_WIDTH        = 3'd0,
		REG_VIS_HEIGHT       = 3'd1,
		REG_LINE_STRIDE      = 3'd2,
		REG_FG_COLOR         = 3'd3,
		REG_BACKGROUND_COLOR = 3'd4
	} reg_idx_t;

	localparam int CFG_DATA_W = 32;

	localparam logic [12:0] RST_VIS_WIDTH   = 13'd640;
	localparam logic [12:0] RST_VIS_HEIGHT  = 13'd480;
	localparam logic [13:0] RST_LINE_STRIDE = 14'd640;
	localparam logic [31:0] RST_FG_COLOR    = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_BG_COLOR    = 32'h0000_0000;

	// Item kinds and control characters
	localparam logic       KIND_FONT = 1'b1;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;

	localparam int CELL_WIDTH  = 8;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [12:0] vis_width;
		logic [12:0] vis_height;
		logic [13:0] line_stride;
		logic [31:0] fg_color;
		logic [31:0] background_color;
	} cfg_t;

	// One queued word between front and back
	typedef struct packed {
		logic        is_font;
		logic [7:0]  code;
		logic [11:0] font_address;
		logic [7:0]  font_byte;
		logic [11:0] col;
		logic [11:0] row;
		logic [24:0] base;     // row * stride + col, mod 2^25
	} entry_t;

endpackage
`default_nettype wire

### hw/rtl/bftr_if.sv
`default_nettype none
interface bftr_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  char_code;
	logic [11:0] font_address;
	logic [7:0]  font_byte;

	modport source (output valid, kind, char_code, font_address, font_byte, input ready);
	modport sink (input valid, kind, char_code, font_address, font_byte, output ready);
endinterface

interface bftr_out_if;
	logic        valid;
	logic        ready;
	logic [24:0] pixel_offset;
	logic [31:0] first_color;
	logic [31:0] second_color;
	logic        first_write;
	logic        second_write;
	logic        last;

	modport source (output valid, pixel_offset, first_color, second_color, first_write,
		second_write, last, input ready);
	modport sink (input valid, pixel_offset, first_color, second_color, first_write,
		second_write, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/bftr_ram.sv
`default_nettype none
module bftr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bftr_front.sv
`default_nettype none
module bftr_front
	import bftr_pkg::*;
#(
	parameter int GLYPH_HEIGHT = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	bftr_in_if.sink     chars,
	output logic        push_valid,
	input  wire logic   push_ready,
	output entry_t      push_entry
);
	localparam logic [12:0] GH13 = 13'(GLYPH_HEIGHT);
	localparam logic [12:0] CW13 = 13'(CELL_WIDTH);

	logic [11:0] col_q, row_q;
	logic [11:0] col_d, row_d;
	logic [11:0] col_m, row_m;
	logic [25:0] prod;
	logic        is_font, is_lf, is_cr, accept;

	// Right edge wrap, then return to top at the bottom
	function automatic logic [23:0] after_move(input logic [11:0] col, input logic [11:0] row,
		input cfg_t c);
		logic [11:0] nc, nr;
		nc = col;
		nr = row;
		if ({1'b0, col} + CW13 > c.vis_width) begin
			nc = '0;
			nr = 12'({1'b0, row} + GH13);
		end
		if ({1'b0, nr} + GH13 > c.vis_height) begin
			nr = '0;
		end
		return {nc, nr};
	endfunction

	assign is_font = chars.kind == KIND_FONT;
	assign is_lf   = !is_font && chars.char_code == CHAR_LF;
	assign is_cr   = !is_font && chars.char_code == CHAR_CR;
	assign accept  = chars.valid && push_ready;

	assign chars.ready = push_ready;
	assign push_valid  = chars.valid && !is_lf && !is_cr;

	assign prod = row_q * cfg.line_stride;

	always_comb begin
		push_entry.is_font      = is_font;
		push_entry.code         = chars.char_code;
		push_entry.font_address = chars.font_address;
		push_entry.font_byte    = chars.font_byte;
		push_entry.col          = col_q;
		push_entry.row          = row_q;
		push_entry.base         = 25'(prod + 26'(col_q));
	end

	always_comb begin
		col_m = col_q;
		row_m = row_q;
		if (is_lf) begin
			col_m = '0;
			row_m = 12'({1'b0, row_q} + GH13);
		end else if (is_cr) begin
			col_m = '0;
		end else begin
			col_m = 12'({1'b0, col_q} + CW13);
		end
		{col_d, row_d} = after_move(col_m, row_m, cfg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && !is_font) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bftr_queue.sv
`default_nettype none
module bftr_queue
	import bftr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire entry_t push_entry,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output entry_t      pop_entry
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	entry_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign push_ready = cnt_q != (PW+1)'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bftr_back.sv
`default_nettype none
module bftr_back
	import bftr_pkg::*;
#(
	parameter int GLYPH_HEIGHT      = 16,
	parameter int FONT_GLYPHS       = 256,
	parameter int PIXELS_PER_RESULT = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   pop_valid,
	output logic        pop_ready,
	input  wire entry_t pop_entry,
	bftr_out_if.source  pixels
);
	localparam int          STORE_SIZE = FONT_GLYPHS * GLYPH_HEIGHT;
	localparam int          AW         = $clog2(STORE_SIZE);
	localparam int          RW         = $clog2(GLYPH_HEIGHT);
	localparam logic [2:0]  STEP       = 3'(PIXELS_PER_RESULT);
	localparam logic [2:0]  LAST_C     = 3'(CELL_WIDTH - PIXELS_PER_RESULT);
	localparam logic [RW-1:0] LAST_R   = RW'(GLYPH_HEIGHT - 1);

	// active character
	logic          busy_q, blank_q;
	logic [7:0]    code_q;
	logic [11:0]   col_q, row_q;
	logic [24:0]   rowoff_q;
	logic [2:0]    c_q;
	logic [RW-1:0] r_q;

	// read stage
	logic          valid_s1, blank_s1, last_s1, x0_s1, x1_s1, y_s1;
	logic [2:0]    c_s1;
	logic [24:0]   off_s1;

	// output register
	logic          out_valid_q;

	logic          pop, issue, s1_ready, out_load, last_pix, font_we;
	logic [AW-1:0] raddr, waddr;
	logic [7:0]    rdata, bits;
	logic [12:0]   x0;

	assign pop_ready = !busy_q;
	assign pop       = pop_valid && pop_ready;
	assign font_we   = pop && pop_entry.is_font && 32'(pop_entry.font_address) < STORE_SIZE;
	assign waddr     = AW'(pop_entry.font_address);

	assign out_load  = valid_s1 && (!out_valid_q || pixels.ready);
	assign s1_ready  = !valid_s1 || out_load;
	assign issue     = busy_q && s1_ready;
	assign last_pix  = c_q == LAST_C && r_q == LAST_R;
	assign raddr     = AW'(32'(code_q) * GLYPH_HEIGHT + 32'(r_q));
	assign x0        = 13'(col_q) + 13'(c_q);

	bftr_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_glyphs (
		.clk   (clk),
		.we    (font_we),
		.waddr (waddr),
		.wdata (pop_entry.font_byte),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop && !pop_entry.is_font) begin
			busy_q <= 1'b1;
		end else if (issue && last_pix) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !pop_entry.is_font) begin
			code_q   <= pop_entry.code;
			blank_q  <= 32'(pop_entry.code) >= FONT_GLYPHS;
			col_q    <= pop_entry.col;
			row_q    <= pop_entry.row;
			rowoff_q <= pop_entry.base;
			c_q      <= '0;
			r_q      <= '0;
		end else if (issue) begin
			if (c_q == LAST_C) begin
				c_q      <= '0;
				r_q      <= r_q + 1'b1;
				rowoff_q <= rowoff_q + 25'(cfg.line_stride);
			end else begin
				c_q <= c_q + STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			c_s1     <= c_q;
			blank_s1 <= blank_q;
			last_s1  <= last_pix;
			off_s1   <= rowoff_q + 25'(c_q);
			x0_s1    <= x0 < cfg.vis_width;
			x1_s1    <= x0 + 13'd1 < cfg.vis_width;
			y_s1     <= 13'(row_q) + 13'(r_q) < cfg.vis_height;
		end
	end

	assign bits = blank_s1 ? 8'h00 : rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixels.pixel_offset <= off_s1;
			pixels.first_color  <= bits[3'd7 - c_s1] ? cfg.fg_color : cfg.background_color;
			pixels.first_write  <= x0_s1 && y_s1;
			pixels.last         <= last_s1;
			if (PIXELS_PER_RESULT > 1) begin
				pixels.second_color <= bits[3'd6 - c_s1] ? cfg.fg_color
					: cfg.background_color;
				pixels.second_write <= x1_s1 && y_s1;
			end else begin
				pixels.second_color <= '0;
				pixels.second_write <= 1'b0;
			end
		end
	end

	assign pixels.valid = out_valid_q;
endmodule
`default_nettype wire

### hw/rtl/bitmap_font_text_renderer_core.sv
// A character's first pixel-pair word passes the queue, the character registers, the
//   read stage and the output register. One word per cycle leaves the glyph store read
//   port while the output is not stalled; a new character waits for the last word.
// Font words are handled in the back end; line feed and carriage return in front.
// Reset (arst_n low, async): cursor at 0,0, queue empty, registers at their defaults;
//   glyph store contents are undefined until loaded.
`default_nettype none
module bitmap_font_text_renderer_core
	import bftr_pkg::*;
#(
	parameter int GLYPH_HEIGHT      = 16,
	parameter int FONT_GLYPHS       = 256,
	parameter int PIXELS_PER_RESULT = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [2:0]            wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	bftr_in_if.sink                    chars,
	bftr_out_if.source                 pixels
);
	// Register file: to be written only while idle (the user's duty; not enforced), so no shadowing is needed.
	cfg_t   cfg_q;

	// front -> queue -> back
	logic   push_valid, push_ready, pop_valid, pop_ready;
	entry_t push_entry, pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vis_width        <= RST_VIS_WIDTH;
			cfg_q.vis_height       <= RST_VIS_HEIGHT;
			cfg_q.line_stride      <= RST_LINE_STRIDE;
			cfg_q.fg_color         <= RST_FG_COLOR;
			cfg_q.background_color <= RST_BG_COLOR;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_VIS_WIDTH:        cfg_q.vis_width        <= wr_data[12:0];
				REG_VIS_HEIGHT:       cfg_q.vis_height       <= wr_data[12:0];
				REG_LINE_STRIDE:      cfg_q.line_stride      <= wr_data[13:0];
				REG_FG_COLOR:         cfg_q.fg_color         <= wr_data;
				REG_BACKGROUND_COLOR: cfg_q.background_color <= wr_data;
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	// Front: owns the cursor, resolves LF/CR locally, computes the cell's base offset.
	bftr_front #(.GLYPH_HEIGHT(GLYPH_HEIGHT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.chars      (chars),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Short queue; font words ride it too so store writes keep order with glyph reads.
	bftr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Back: glyph store, pixel sequencer, read stage and output register.
	bftr_back #(
		.GLYPH_HEIGHT      (GLYPH_HEIGHT),
		.FONT_GLYPHS       (FONT_GLYPHS),
		.PIXELS_PER_RESULT (PIXELS_PER_RESULT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.pixels    (pixels)
	);
endmodule
`default_nettype wire

### hw/rtl/bftr_checker.sv
`default_nettype none
module bftr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [24:0] pixel_offset,
	input wire logic [31:0] first_color,
	input wire logic [31:0] second_color,
	input wire logic        first_write,
	input wire logic        second_write,
	input wire logic        last
);
	// No output word can be valid right after reset.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !valid)
		else $error("output word valid right after reset");

	// The second pixel sits one column right of the first on the same line, so it is written only if the first is.
	a_clip_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid && second_write |-> first_write)
		else $error("second pixel written while first is clipped");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("output word dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(pixel_offset) && $stable(first_color)
			&& $stable(second_color) && $stable(last))
		else $error("output word changed under stall");
endmodule

bind bitmap_font_text_renderer_core bftr_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (pixels.valid),
	.ready        (pixels.ready),
	.pixel_offset (pixels.pixel_offset),
	.first_color  (pixels.first_color),
	.second_color (pixels.second_color),
	.first_write  (pixels.first_write),
	.second_write (pixels.second_write),
	.last         (pixels.last)
);
`default_nettype wire
